FILE: src/oms_pkg.sv
// Shared types, step codes and arctangent table for the odometry motion state block.
`default_nettype none
package oms_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_CLAMP,
    ST_SQRT_LD,
    ST_SQRT,
    ST_CORD_LD,
    ST_NORM,
    ST_ROT,
    ST_DONE
  } oms_state_e;

  // Product codes for the shared multiplier
  localparam logic [3:0] K_VXX   = 4'd0;
  localparam logic [3:0] K_VYY   = 4'd1;
  localparam logic [3:0] K_XZ    = 4'd2;
  localparam logic [3:0] K_WY    = 4'd3;
  localparam logic [3:0] K_YZ    = 4'd4;
  localparam logic [3:0] K_WX    = 4'd5;
  localparam logic [3:0] K_XY    = 4'd6;
  localparam logic [3:0] K_WZ    = 4'd7;
  localparam logic [3:0] K_WW    = 4'd8;
  localparam logic [3:0] K_XX    = 4'd9;
  localparam logic [3:0] K_YY    = 4'd10;
  localparam logic [3:0] K_ZZ    = 4'd11;
  localparam logic [3:0] K_SS    = 4'd12;
  localparam logic [3:0] K_ACCEL = 4'd13;
  localparam logic [3:0] K_BRAKE = 4'd14;

  // Angle selection for the CORDIC runs
  localparam logic [1:0] CI_ROLL  = 2'd0;
  localparam logic [1:0] CI_PITCH = 2'd1;
  localparam logic [1:0] CI_YAW   = 2'd2;

  // Root operand selection
  localparam logic SQ_SPEED = 1'b0;
  localparam logic SQ_COS   = 1'b1;

  // Register indexes
  localparam logic REG_RATE  = 1'b0;
  localparam logic REG_BRAKE = 1'b1;

  localparam int unsigned CW       = 48;
  localparam int unsigned SQW      = 57;
  localparam int unsigned ROT_LAST = 29;
  localparam int unsigned SQ_LAST  = 28;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/odometry_motion_state.sv
// Odometry motion state: speed, acceleration, brake distance and Euler angles per sample.
//
// Usage: one odometry sample enters on the input channel (valid/ready) and one result
// leaves on the output channel (valid/ready). Configuration (sample rate, brake time
// coefficient) is written through cfg_we_i/cfg_addr_i/cfg_wdata_i while the block is idle.
// A sample is worked on by one sequencer that reuses a single 30x30 multiplier, a
// two-bits-per-cycle square root unit and one CORDIC rotator. In order, a sample passes
// through the idle state in which the transaction is taken, 15 products (each a multiply
// and an accumulate step), a clamp, 2 roots (load plus 29 steps), then three CORDIC runs,
// each a load, a normalisation that doubles both operands until the larger one reaches
// 2^40, and the rotation steps (a run with both operands zero is skipped after its load);
// and last a step to hand over the result. in_ready_o is high only while no sample is in
// work, so a new sample is not taken before the last one has left the sequencer.
// The result sits in an output register; a new sample is taken while it waits, and
// the finished result of that sample is held back until the previous one is taken.
// Reset clears the previous speed, loads the register defaults (100 Hz, 1.0 s) and
// empties the output register.
`default_nettype none
module odometry_motion_state (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_addr_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [17:0] vel_x_i,
  input  wire logic signed [17:0] vel_y_i,
  input  wire logic signed [15:0] quat_x_i,
  input  wire logic signed [15:0] quat_y_i,
  input  wire logic signed [15:0] quat_z_i,
  input  wire logic signed [15:0] quat_w_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [17:0]             speed_o,
  output logic signed [28:0]      accel_o,
  output logic signed [15:0]      roll_o,
  output logic signed [15:0]      pitch_o,
  output logic signed [15:0]      yaw_o,
  output logic [25:0]             brake_distance_o
);
  import oms_pkg::*;

  localparam logic signed [CW-1:0]  LIM    = CW'(64'sd1 <<< 40);
  localparam logic signed [34:0]    S_ONE  = 35'sd268435456;
  localparam logic [SQW-1:0]        SQ_TOP = SQW'(1) << 56;

  oms_state_e state_q, state_d;

  logic [9:0]  rate_q;
  logic [15:0] coeff_q;
  logic [17:0] prev_q;

  logic signed [17:0] vx_q, vy_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;

  logic [3:0]          k_q;
  logic signed [59:0]  prod_q;
  logic signed [29:0]  mul_a, mul_b;
  logic signed [59:0]  mul_p;

  logic [35:0]        n_q;
  logic signed [32:0] sacc_q, ry_q, yy_q;
  logic signed [32:0] rx_q, yx_q;
  logic signed [29:0] s_q;
  logic [56:0]        ss_q;
  logic [28:0]        c_q;
  logic [17:0]        sp_q;
  logic signed [28:0] accel_q;
  logic [25:0]        brake_q;

  logic            sq_sel_q;
  logic [4:0]      cnt_q;
  logic [SQW-1:0]  v_q, r_q;
  logic [SQW-1:0]  sq_b;
  logic [SQW:0]    sq_sum;
  logic            sq_take;

  logic [1:0]            ci_q;
  logic signed [CW-1:0]  x_q, y_q;
  logic [31:0]           z_q, z_nx;
  logic signed [CW-1:0]  ld_x, ld_y, xs, ys;
  logic                  norm_small;
  logic [15:0]           ang_nx;
  logic signed [15:0]    roll_q, pitch_q, yaw_q;

  logic signed [34:0] s_neg2;
  logic signed [18:0] sp_diff;

  logic out_valid_q;

  // ---------------- combinational helpers ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sp_diff = $signed({1'b0, sp_q}) - $signed({1'b0, prev_q});
    case (k_q)
      K_VXX: begin mul_a = 30'(vx_q); mul_b = 30'(vx_q); end
      K_VYY: begin mul_a = 30'(vy_q); mul_b = 30'(vy_q); end
      K_XZ:  begin mul_a = 30'(qx_q); mul_b = 30'(qz_q); end
      K_WY:  begin mul_a = 30'(qw_q); mul_b = 30'(qy_q); end
      K_YZ:  begin mul_a = 30'(qy_q); mul_b = 30'(qz_q); end
      K_WX:  begin mul_a = 30'(qw_q); mul_b = 30'(qx_q); end
      K_XY:  begin mul_a = 30'(qx_q); mul_b = 30'(qy_q); end
      K_WZ:  begin mul_a = 30'(qw_q); mul_b = 30'(qz_q); end
      K_WW:  begin mul_a = 30'(qw_q); mul_b = 30'(qw_q); end
      K_XX:  begin mul_a = 30'(qx_q); mul_b = 30'(qx_q); end
      K_YY:  begin mul_a = 30'(qy_q); mul_b = 30'(qy_q); end
      K_ZZ:  begin mul_a = 30'(qz_q); mul_b = 30'(qz_q); end
      K_SS:  begin mul_a = s_q; mul_b = s_q; end
      K_ACCEL: begin
        mul_a = 30'(sp_diff);
        mul_b = $signed({20'd0, rate_q});
      end
      K_BRAKE: begin
        mul_a = $signed({12'd0, sp_q});
        mul_b = $signed({14'd0, coeff_q});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign s_neg2 = -($signed({sacc_q[32], sacc_q, 1'b0}));

  // root step: b = 4^(28-cnt)
  assign sq_b    = SQ_TOP >> {cnt_q, 1'b0};
  assign sq_sum  = {1'b0, r_q} + {1'b0, sq_b};
  assign sq_take = ({1'b0, v_q} >= sq_sum);

  always_comb begin
    ld_x = '0;
    ld_y = '0;
    case (ci_q)
      CI_ROLL: begin
        ld_y = CW'($signed({ry_q, 1'b0}));
        ld_x = CW'(rx_q);
      end
      CI_PITCH: begin
        ld_y = CW'(s_q);
        ld_x = CW'({1'b0, c_q});
      end
      CI_YAW: begin
        ld_y = CW'($signed({yy_q, 1'b0}));
        ld_x = CW'(yx_q);
      end
      default: begin ld_x = '0; ld_y = '0; end
    endcase
  end

  assign norm_small = (x_q < LIM) && (x_q > -LIM) && (y_q < LIM) && (y_q > -LIM);
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign z_nx = y_q[CW-1] ? (z_q - atan_lut(cnt_q)) : (z_q + atan_lut(cnt_q));
  assign ang_nx = 16'((z_nx + 32'h8000) >> 16);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        unique case (k_q)
          K_ZZ:    state_d = ST_CLAMP;
          K_SS:    state_d = ST_SQRT_LD;
          K_BRAKE: state_d = ST_SQRT_LD;
          default: state_d = ST_MUL;
        endcase
      end
      ST_CLAMP:   state_d = ST_MUL;
      ST_SQRT_LD: state_d = ST_SQRT;
      ST_SQRT: begin
        if (cnt_q == 5'(SQ_LAST)) begin
          state_d = (sq_sel_q == SQ_SPEED) ? ST_MUL : ST_CORD_LD;
        end
      end
      ST_CORD_LD: begin
        if (ld_x == '0 && ld_y == '0) begin
          state_d = (ci_q == CI_YAW) ? ST_DONE : ST_CORD_LD;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: if (!norm_small) state_d = ST_ROT;
      ST_ROT: begin
        if (cnt_q == 5'(ROT_LAST)) begin
          state_d = (ci_q == CI_YAW) ? ST_DONE : ST_CORD_LD;
        end
      end
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= 10'd100;
      coeff_q     <= 16'd256;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_RATE) rate_q  <= cfg_wdata_i[9:0];
        if (cfg_addr_i == REG_BRAKE) coeff_q <= cfg_wdata_i;
      end
      if (state_q == ST_ACC && k_q == K_ACCEL) prev_q <= sp_q;
      if (state_q == ST_DONE && state_d == ST_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          vx_q <= vel_x_i;  vy_q <= vel_y_i;
          qx_q <= quat_x_i; qy_q <= quat_y_i;
          qz_q <= quat_z_i; qw_q <= quat_w_i;
          k_q <= K_VXX;
          n_q <= '0; sacc_q <= '0; ry_q <= '0; yy_q <= '0; rx_q <= '0; yx_q <= '0;
        end
      end
      ST_MUL: prod_q <= mul_p;
      ST_ACC: begin
        k_q <= k_q + 4'd1;
        case (k_q)
          K_VXX, K_VYY: n_q <= n_q + prod_q[35:0];
          K_XZ:         sacc_q <= sacc_q + prod_q[32:0];
          K_WY:         sacc_q <= sacc_q - prod_q[32:0];
          K_YZ, K_WX:   ry_q <= ry_q + prod_q[32:0];
          K_XY, K_WZ:   yy_q <= yy_q + prod_q[32:0];
          K_WW: begin rx_q <= rx_q + prod_q[32:0]; yx_q <= yx_q + prod_q[32:0]; end
          K_XX: begin rx_q <= rx_q - prod_q[32:0]; yx_q <= yx_q + prod_q[32:0]; end
          K_YY: begin rx_q <= rx_q - prod_q[32:0]; yx_q <= yx_q - prod_q[32:0]; end
          K_ZZ: begin rx_q <= rx_q + prod_q[32:0]; yx_q <= yx_q - prod_q[32:0]; end
          K_SS: begin
            ss_q     <= prod_q[56:0];
            sq_sel_q <= SQ_SPEED;
          end
          K_ACCEL: accel_q <= prod_q[28:0];
          K_BRAKE: begin
            brake_q  <= prod_q[33:8];
            sq_sel_q <= SQ_COS;
          end
          default: ;
        endcase
      end
      ST_CLAMP: begin
        // pitch argument held to plus or minus one
        if (s_neg2 > S_ONE)       s_q <= 30'(S_ONE);
        else if (s_neg2 < -S_ONE) s_q <= 30'(-S_ONE);
        else                      s_q <= 30'(s_neg2);
      end
      ST_SQRT_LD: begin
        v_q   <= (sq_sel_q == SQ_SPEED) ? SQW'(n_q) : (SQ_TOP - ss_q);
        r_q   <= '0;
        cnt_q <= '0;
      end
      ST_SQRT: begin
        if (sq_take) begin
          v_q <= v_q - sq_sum[SQW-1:0];
          r_q <= (r_q >> 1) + sq_b;
        end else begin
          r_q <= r_q >> 1;
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(SQ_LAST)) begin
          ci_q <= CI_ROLL;
          if (sq_sel_q == SQ_SPEED) begin
            // remainder left in v is n - root^2; round up when above the root
            sp_q <= sq_take ? 18'(((r_q >> 1) + sq_b) + SQW'((v_q - sq_sum[SQW-1:0])
                              > ((r_q >> 1) + sq_b)))
                            : 18'((r_q >> 1) + SQW'(v_q > (r_q >> 1)));
          end else begin
            c_q <= sq_take ? 29'((r_q >> 1) + sq_b) : 29'(r_q >> 1);
          end
        end
      end
      ST_CORD_LD: begin
        x_q   <= ld_x;
        y_q   <= ld_y;
        cnt_q <= '0;
        if (ld_x == '0 && ld_y == '0) begin
          ci_q <= ci_q + 2'd1;
          case (ci_q)
            CI_ROLL:  roll_q  <= '0;
            CI_PITCH: pitch_q <= '0;
            default:  yaw_q   <= '0;
          endcase
        end
      end
      ST_NORM: begin
        if (norm_small) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end else if (x_q[CW-1]) begin
          x_q <= -x_q;
          y_q <= -y_q;
          z_q <= 32'h80000000;
        end else begin
          z_q <= '0;
        end
      end
      ST_ROT: begin
        if (y_q[CW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
        end
        z_q   <= z_nx;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(ROT_LAST)) begin
          cnt_q <= '0;
          ci_q  <= ci_q + 2'd1;
          case (ci_q)
            CI_ROLL:  roll_q  <= ang_nx;
            CI_PITCH: pitch_q <= ang_nx;
            default:  yaw_q   <= ang_nx;
          endcase
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          speed_o          <= sp_q;
          accel_o          <= accel_q;
          roll_o           <= roll_q;
          pitch_o          <= pitch_q;
          yaw_o            <= yaw_q;
          brake_distance_o <= brake_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // ---------------- checks ----------------
  ap_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MUL))
    else $error("sample accepted but sequencer did not start");

  ap_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (cnt_q <= 5'(SQ_LAST)))
    else $error("root step count out of range");

  ap_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (cnt_q <= 5'(ROT_LAST)))
    else $error("CORDIC step count out of range");

  ap_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !out_ready_i) |=> (state_q == ST_DONE))
    else $error("finished result overtook a pending one");

  ap_prev_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == ST_ACC && k_q == K_ACCEL) |=> $stable(prev_q))
    else $error("previous speed changed outside its update step");

endmodule
`default_nettype wire
